// ----- sv/hsbrgb_pkg.sv -----
package hsbrgb_pkg;

  // Field widths of the input and output words.
  localparam int unsigned HueW  = 15;
  localparam int unsigned SatW  = 15;
  localparam int unsigned ChanW = 16;

  // Number of register stages between the input and the output port.
  localparam int unsigned PipeDepth = 6;

  // Hue sector width (60 degrees times 64) and saturation scale.
  localparam int unsigned SectorQ6 = 3840;
  localparam int unsigned SatFull  = 25600;
  localparam int unsigned SatMin   = 256;
  localparam int unsigned SatRange = SatFull * SectorQ6;

  // p divides by 25600 = 2^10 * 25, q and t divide by 98304000 = 2^18 * 375.
  // Each odd divisor is handled by a reciprocal multiply and one correction.
  localparam int unsigned PreShP   = 10;
  localparam int unsigned DivP     = 25;
  localparam int unsigned RecipShP = 26;
  localparam int unsigned RecipP   = (1 << RecipShP) / DivP;
  localparam int unsigned PreShQ   = 18;
  localparam int unsigned DivQ     = 375;
  localparam int unsigned RecipShQ = 34;
  localparam longint unsigned RecipQ = (64'd1 << RecipShQ) / DivQ;

  // Sector code used for channel routing; hues past 360 degrees use sector five.
  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_e;

endpackage

// ----- sv/hsbrgb_in_if.sv -----
interface hsbrgb_in_if;
  import hsbrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue_deg_q6;
  logic [SatW-1:0]  sat_pct_q8;
  logic [ChanW-1:0] brightness;

  modport source (output valid, hue_deg_q6, sat_pct_q8, brightness, input ready);
  modport sink   (input valid, hue_deg_q6, sat_pct_q8, brightness, output ready);

endinterface

// ----- sv/hsbrgb_out_if.sv -----
interface hsbrgb_out_if;
  import hsbrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);

endinterface

// ----- sv/hsb_to_rgb_convert.sv -----
// HSB to RGB color converter.
//
// Input channel in_i carries one color word per handshake: hue in degrees
// times 64, saturation in percent times 256 and brightness as a Q0.16
// fraction. Output channel out_o carries the red, green and blue Q0.16
// channels. A word is transferred when valid and ready are both high.
//
// The datapath is a six-stage pipeline; an accepted word passes through all
// stage registers before reaching out_o. One word enters per cycle unless
// out_o stalls; the rate is set by the pipeline stages, with the 16 by 27
// bit products and the reciprocal multiplies each taking a stage of their own.
//
// Each stage holds a valid bit and advances whenever the stage after it is
// empty or moving, so empty slots are squeezed out while the receiver
// stalls. Input ready drops only when all six stages hold a word and the
// output is not taken. Reset clears all valid bits; the pipeline starts
// empty and accepts a word in the first cycle after reset.
module hsb_to_rgb_convert (
  input  logic   clk_i,
  input  logic   rst_ni,
  hsbrgb_in_if.sink    in_i,
  hsbrgb_out_if.source out_o
);
  import hsbrgb_pkg::*;

  localparam int unsigned RemW  = 12;
  localparam int unsigned ProdW = 27;
  localparam int unsigned XpW   = ChanW + SatW;
  localparam int unsigned XqW   = ChanW + ProdW;
  localparam int unsigned YpW   = XpW - PreShP;
  localparam int unsigned YqW   = XqW - PreShQ;
  localparam int unsigned MpW   = 22;
  localparam int unsigned MqW   = 26;

  // Stage valid bits and per-stage load enables.
  logic [PipeDepth-1:0] v_q;
  logic [PipeDepth-1:0] en;

  always_comb begin
    en[PipeDepth-1] = !v_q[PipeDepth-1] || out_o.ready;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < PipeDepth; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: split the hue into sector and remainder, clamp and test saturation.
  logic [3:0]       sec_raw;
  logic [RemW-1:0]  rem_d;
  sector_e          sec_d;
  logic [SatW-1:0]  sat_d;
  logic             low_d;

  always_comb begin
    sec_raw = '0;
    for (int k = 1; k <= 8; k++) begin
      if (in_i.hue_deg_q6 >= HueW'(k * SectorQ6)) begin
        sec_raw = 4'(k);
      end
    end
    rem_d = RemW'(in_i.hue_deg_q6 - HueW'(int'(sec_raw) * SectorQ6));
    sec_d = (sec_raw >= 4'd5) ? SEC_5 : sector_e'(sec_raw[2:0]);
    sat_d = (in_i.sat_pct_q8 > SatW'(SatFull)) ? SatW'(SatFull) : in_i.sat_pct_q8;
    low_d = in_i.sat_pct_q8 < SatW'(SatMin);
  end

  logic [ChanW-1:0] b1_q;
  logic [RemW-1:0]  rem1_q;
  sector_e          sec1_q;
  logic [SatW-1:0]  sat1_q;
  logic             low1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      b1_q   <= in_i.brightness;
      rem1_q <= rem_d;
      sec1_q <= sec_d;
      sat1_q <= sat_d;
      low1_q <= low_d;
    end
  end

  // Stage 2: saturation times the sector fraction and its complement.
  logic [RemW-1:0]  comp_d;
  logic [ProdW-1:0] sr_d;
  logic [ProdW-1:0] st_d;
  logic [ProdW-1:0] dq_d;
  logic [ProdW-1:0] dt_d;
  logic [SatW-1:0]  dp_d;

  always_comb begin
    comp_d = RemW'(SectorQ6) - rem1_q;
    sr_d   = {{(ProdW-SatW){1'b0}}, sat1_q} * {{(ProdW-RemW){1'b0}}, rem1_q};
    st_d   = {{(ProdW-SatW){1'b0}}, sat1_q} * {{(ProdW-RemW){1'b0}}, comp_d};
    dq_d   = ProdW'(SatRange) - sr_d;
    dt_d   = ProdW'(SatRange) - st_d;
    dp_d   = SatW'(SatFull) - sat1_q;
  end

  logic [ChanW-1:0] b2_q;
  sector_e          sec2_q;
  logic             low2_q;
  logic [SatW-1:0]  dp2_q;
  logic [ProdW-1:0] dq2_q;
  logic [ProdW-1:0] dt2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b2_q   <= b1_q;
      sec2_q <= sec1_q;
      low2_q <= low1_q;
      dp2_q  <= dp_d;
      dq2_q  <= dq_d;
      dt2_q  <= dt_d;
    end
  end

  // Stage 3: scale by brightness and drop the power-of-two part of the divisor.
  logic [XpW-1:0] xp_d;
  logic [XqW-1:0] xq_d;
  logic [XqW-1:0] xt_d;

  always_comb begin
    xp_d = {{(XpW-ChanW){1'b0}}, b2_q} * {{(XpW-SatW){1'b0}}, dp2_q};
    xq_d = {{(XqW-ChanW){1'b0}}, b2_q} * {{(XqW-ProdW){1'b0}}, dq2_q};
    xt_d = {{(XqW-ChanW){1'b0}}, b2_q} * {{(XqW-ProdW){1'b0}}, dt2_q};
  end

  logic [ChanW-1:0] b3_q;
  sector_e          sec3_q;
  logic             low3_q;
  logic [YpW-1:0]   yp3_q;
  logic [YqW-1:0]   yq3_q;
  logic [YqW-1:0]   yt3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      b3_q   <= b2_q;
      sec3_q <= sec2_q;
      low3_q <= low2_q;
      yp3_q  <= YpW'(xp_d >> PreShP);
      yq3_q  <= YqW'(xq_d >> PreShQ);
      yt3_q  <= YqW'(xt_d >> PreShQ);
    end
  end

  // Stage 4: quotient estimates by reciprocal multiply, low by at most one.
  logic [YpW+MpW-1:0] mp_d;
  logic [YqW+MqW-1:0] mq_d;
  logic [YqW+MqW-1:0] mt_d;

  always_comb begin
    mp_d = {{MpW{1'b0}}, yp3_q} * {{YpW{1'b0}}, MpW'(RecipP)};
    mq_d = {{MqW{1'b0}}, yq3_q} * {{YqW{1'b0}}, MqW'(RecipQ)};
    mt_d = {{MqW{1'b0}}, yt3_q} * {{YqW{1'b0}}, MqW'(RecipQ)};
  end

  logic [ChanW-1:0] b4_q;
  sector_e          sec4_q;
  logic             low4_q;
  logic [YpW-1:0]   yp4_q;
  logic [YqW-1:0]   yq4_q;
  logic [YqW-1:0]   yt4_q;
  logic [ChanW-1:0] ep4_q;
  logic [ChanW-1:0] eq4_q;
  logic [ChanW-1:0] et4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      b4_q   <= b3_q;
      sec4_q <= sec3_q;
      low4_q <= low3_q;
      yp4_q  <= yp3_q;
      yq4_q  <= yq3_q;
      yt4_q  <= yt3_q;
      ep4_q  <= ChanW'(mp_d >> RecipShP);
      eq4_q  <= ChanW'(mq_d >> RecipShQ);
      et4_q  <= ChanW'(mt_d >> RecipShQ);
    end
  end

  // Stage 5: correct each estimate with one multiply-back and compare.
  logic [YpW-1:0]   rp_d;
  logic [YqW-1:0]   rq_d;
  logic [YqW-1:0]   rt_d;
  logic [ChanW-1:0] p_d;
  logic [ChanW-1:0] q_d;
  logic [ChanW-1:0] t_d;

  always_comb begin
    rp_d = yp4_q - {{(YpW-ChanW){1'b0}}, ep4_q} * YpW'(DivP);
    rq_d = yq4_q - {{(YqW-ChanW){1'b0}}, eq4_q} * YqW'(DivQ);
    rt_d = yt4_q - {{(YqW-ChanW){1'b0}}, et4_q} * YqW'(DivQ);
    p_d  = (rp_d >= YpW'(DivP)) ? ep4_q + 1'b1 : ep4_q;
    q_d  = (rq_d >= YqW'(DivQ)) ? eq4_q + 1'b1 : eq4_q;
    t_d  = (rt_d >= YqW'(DivQ)) ? et4_q + 1'b1 : et4_q;
  end

  logic [ChanW-1:0] b5_q;
  sector_e          sec5_q;
  logic             low5_q;
  logic [ChanW-1:0] p5_q;
  logic [ChanW-1:0] q5_q;
  logic [ChanW-1:0] t5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      b5_q   <= b4_q;
      sec5_q <= sec4_q;
      low5_q <= low4_q;
      p5_q   <= p_d;
      q5_q   <= q_d;
      t5_q   <= t_d;
    end
  end

  // Stage 6: route brightness, p, q and t onto the channels by sector.
  logic [ChanW-1:0] r_d;
  logic [ChanW-1:0] g_d;
  logic [ChanW-1:0] bl_d;

  always_comb begin
    case (sec5_q)
      SEC_0: begin
        r_d = b5_q; g_d = t5_q; bl_d = p5_q;
      end
      SEC_1: begin
        r_d = q5_q; g_d = b5_q; bl_d = p5_q;
      end
      SEC_2: begin
        r_d = p5_q; g_d = b5_q; bl_d = t5_q;
      end
      SEC_3: begin
        r_d = p5_q; g_d = q5_q; bl_d = b5_q;
      end
      SEC_4: begin
        r_d = t5_q; g_d = p5_q; bl_d = b5_q;
      end
      default: begin
        r_d = b5_q; g_d = p5_q; bl_d = q5_q;
      end
    endcase
    // Nearly gray colors pass the brightness to all channels.
    if (low5_q) begin
      r_d  = b5_q;
      g_d  = b5_q;
      bl_d = b5_q;
    end
  end

  logic [ChanW-1:0] r6_q;
  logic [ChanW-1:0] g6_q;
  logic [ChanW-1:0] bl6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      r6_q  <= r_d;
      g6_q  <= g_d;
      bl6_q <= bl_d;
    end
  end

  assign out_o.valid     = v_q[PipeDepth-1];
  assign out_o.red_out   = r6_q;
  assign out_o.green_out = g6_q;
  assign out_o.blue_out  = bl6_q;

endmodule

// ----- sv/hsbrgb_checker.sv -----
module hsbrgb_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [hsbrgb_pkg::ChanW-1:0] red_i,
  input logic [hsbrgb_pkg::ChanW-1:0] green_i,
  input logic [hsbrgb_pkg::ChanW-1:0] blue_i
);
  import hsbrgb_pkg::*;

  // Count of words accepted at the input and not yet taken at the output.
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (in_valid_i && in_ready_i) begin
      cnt_d = cnt_d + 3'd1;
    end
    if (out_valid_i && out_ready_i) begin
      cnt_d = cnt_d - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i))
    else $error("output word changed while stalled");

  // The input is held off only by a stalled output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // While the pipeline has a free slot, the input is ready.
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 3'(PipeDepth) |-> in_ready_i)
    else $error("input stalled with a free pipeline slot");

  // No word appears without one in flight, and no more than the depth is held.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i |-> cnt_q != 3'd0) && cnt_q <= 3'(PipeDepth))
    else $error("output word without matching input word");

endmodule

bind hsb_to_rgb_convert hsbrgb_checker u_hsbrgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red_out),
  .green_i     (out_o.green_out),
  .blue_i      (out_o.blue_out)
);

// ----- verif/tb_hsb_to_rgb_convert.sv -----
module tb_hsb_to_rgb_convert;
  timeunit 1ns;
  timeprecision 1ps;

  import hsbrgb_pkg::*;

  // Cycle budget for the whole run, well above the slowest legal schedule.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 1100;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  sat;
    logic [ChanW-1:0] bright;
  } hsb_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_FULL,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  hsbrgb_in_if  in_if ();
  hsbrgb_out_if out_if ();

  hsb_to_rgb_convert i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hsb_t        hsb_pending_q[$];
  rgb_t        rgb_expected_q[$];
  hsb_t        drive_word;
  rgb_t        exp_rgb;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_e    rx_mode;
  int unsigned rx_left;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // Hexcone conversion: exact products, one truncating division per value.
  function automatic rgb_t hsb_to_rgb(logic [HueW-1:0] hue, logic [SatW-1:0] sat,
                                      logic [ChanW-1:0] bright);
    longint unsigned b;
    longint unsigned s;
    longint unsigned rem;
    longint unsigned span;
    longint unsigned p;
    longint unsigned q;
    longint unsigned t;
    int unsigned     sec_num;
    sector_e         sec;
    rgb_t            res;
    b    = 64'(bright);
    span = 64'(SatRange);
    if (sat < SatMin) begin
      res = {bright, bright, bright};
    end else begin
      sec_num = hue / SectorQ6;
      rem     = 64'(hue % SectorQ6);
      // Hues of 360 degrees and beyond are routed like the last sector.
      sec     = (sec_num >= 5) ? SEC_5 : sector_e'(sec_num);
      // Saturation above 100 percent is clamped.
      s = (sat > SatFull) ? 64'(SatFull) : 64'(sat);
      p = (b * (64'(SatFull) - s)) / 64'(SatFull);
      q = (b * (span - s * rem)) / span;
      t = (b * (span - s * (64'(SectorQ6) - rem))) / span;
      case (sec)
        SEC_0:   res = {ChanW'(b), ChanW'(t), ChanW'(p)};
        SEC_1:   res = {ChanW'(q), ChanW'(b), ChanW'(p)};
        SEC_2:   res = {ChanW'(p), ChanW'(b), ChanW'(t)};
        SEC_3:   res = {ChanW'(p), ChanW'(q), ChanW'(b)};
        SEC_4:   res = {ChanW'(t), ChanW'(p), ChanW'(b)};
        default: res = {ChanW'(b), ChanW'(p), ChanW'(q)};
      endcase
    end
    return res;
  endfunction

  // Random color word, weighted toward sector edges and saturation limits.
  function automatic hsb_t random_hsb();
    hsb_t w;
    w.hue    = HueW'($urandom_range(0, SectorQ6 * 6 - 1));
    w.sat    = SatW'($urandom_range(SatMin, SatFull));
    w.bright = ChanW'($urandom);
    case ($urandom_range(0, 9))
      6: w.sat = SatW'($urandom_range(0, SatMin - 1));
      7: begin
        w.hue = HueW'($urandom);
        w.sat = SatW'($urandom);
      end
      8: begin
        w.hue = HueW'($urandom_range(0, 8) * SectorQ6);
        case ($urandom_range(0, 2))
          0: w.hue = HueW'(w.hue + 1);
          1: w.hue = (w.hue == 0) ? w.hue : HueW'(w.hue - 1);
          default: ;
        endcase
      end
      9: begin
        case ($urandom_range(0, 3))
          0: w.sat = SatW'(SatFull);
          1: w.sat = SatW'(SatFull - 1);
          2: w.sat = SatW'(SatMin);
          default: w.sat = SatW'(SatFull + 1);
        endcase
      end
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0: w.bright = '0;
      1: w.bright = '1;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: words leave the pending queue in bursts separated by gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.hue_deg_q6 <= '0;
      in_if.sat_pct_q8 <= '0;
      in_if.brightness <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        rgb_expected_q.push_back(hsb_to_rgb(in_if.hue_deg_q6, in_if.sat_pct_q8,
                                            in_if.brightness));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (hsb_pending_q.size() > 0) begin
          drive_word = hsb_pending_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.hue_deg_q6 <= drive_word.hue;
          in_if.sat_pct_q8 <= drive_word.sat;
          in_if.brightness <= drive_word.bright;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              3:       gap_left = $urandom_range(5, 20);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output word and stalls on its own pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode = RX_FULL;
      rx_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (rgb_expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual r=%h g=%h b=%h", $time,
                   out_if.red_out, out_if.green_out, out_if.blue_out);
          mismatch_cnt++;
        end else begin
          exp_rgb = rgb_expected_q.pop_front();
          if (out_if.red_out !== exp_rgb.red) begin
            $display("%0t: red mismatch, expected %h, actual %h", $time,
                     exp_rgb.red, out_if.red_out);
            mismatch_cnt++;
          end
          if (out_if.green_out !== exp_rgb.green) begin
            $display("%0t: green mismatch, expected %h, actual %h", $time,
                     exp_rgb.green, out_if.green_out);
            mismatch_cnt++;
          end
          if (out_if.blue_out !== exp_rgb.blue) begin
            $display("%0t: blue mismatch, expected %h, actual %h", $time,
                     exp_rgb.blue, out_if.blue_out);
            mismatch_cnt++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FULL:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= cycle_cnt[2];
      endcase
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.hue_deg_q6 = '0;
    in_if.sat_pct_q8 = '0;
    in_if.brightness = '0;
    out_if.ready     = 1'b0;
    mismatch_cnt     = 0;
    cycle_cnt        = 0;

    // Directed words: field extremes, every sector, low saturation,
    // saturation clamping and hues past 360 degrees.
    hsb_pending_q.push_back('{15'd0,     15'd0,     16'h0000});
    hsb_pending_q.push_back('{15'd0,     15'd0,     16'hFFFF});
    hsb_pending_q.push_back('{15'd5000,  15'd255,   16'h8000});
    hsb_pending_q.push_back('{15'd0,     15'd256,   16'hFFFF});
    hsb_pending_q.push_back('{15'd0,     15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'd3839,  15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'd3840,  15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'd9600,  15'd12800, 16'hC000});
    hsb_pending_q.push_back('{15'd11520, 15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'd15460, 15'd20000, 16'h1234});
    hsb_pending_q.push_back('{15'd19200, 15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'd23039, 15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'd23040, 15'd25600, 16'hFFFF});
    hsb_pending_q.push_back('{15'h7FFF,  15'h7FFF,  16'hFFFF});
    hsb_pending_q.push_back('{15'd1000,  15'd25601, 16'hABCD});
    hsb_pending_q.push_back('{15'h7FFF,  15'd0,     16'h5555});
    hsb_pending_q.push_back('{15'h2AAA,  15'h2AAA,  16'hAAAA});
    hsb_pending_q.push_back('{15'h5555,  15'h5555,  16'h5555});
    hsb_pending_q.push_back('{15'd1920,  15'd25599, 16'h0001});
    hsb_pending_q.push_back('{15'd26880, 15'd30000, 16'h7FFF});

    for (int i = 0; i < RandomWords; i++) begin
      hsb_pending_q.push_back(random_hsb());
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every word has been sent and every result has arrived.
    do begin
      @(negedge clk_i);
    end while (hsb_pending_q.size() != 0 || in_if.valid || rgb_expected_q.size() != 0);
    repeat (4 * PipeDepth) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
